// File: rtl/csem_pkg.sv
package csem_pkg;

  localparam int MAX_WAITERS = 16;
  localparam int COUNT_MAX   = 65535;
  localparam int COUNT_W     = 16;
  localparam int ID_W        = 8;
  localparam int CMD_W       = 2;
  localparam int STATUS_W    = 3;
  localparam int WQ_IDX_W    = (MAX_WAITERS > 1) ? $clog2(MAX_WAITERS) : 1;
  localparam int OCC_W       = $clog2(MAX_WAITERS + 1);

  localparam int S_DATA_W = ((CMD_W + ID_W + 7) / 8) * 8;
  localparam int M_DATA_W = ((STATUS_W + 1 + ID_W + COUNT_W + 7) / 8) * 8;

  typedef enum logic [CMD_W-1:0] {
    CMD_WAIT     = 2'd0,
    CMD_POST     = 2'd1,
    CMD_TRY_WAIT = 2'd2,
    CMD_READ     = 2'd3
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK     = 3'd0,
    STAT_QUEUED = 3'd1,
    STAT_BUSY   = 3'd2,
    STAT_FULL   = 3'd3,
    STAT_SAT    = 3'd4
  } status_t;

  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } state_t;

  typedef struct packed {
    logic load;
    logic commit;
  } ctrl_cmd_t;

  typedef struct packed {
    logic out_free;
  } dp_stat_t;

endpackage

// File: rtl/csem_ram.sv
module csem_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/csem_ctrl.sv
module csem_ctrl import csem_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      s_tvalid,
  output logic      s_tready,
  input  dp_stat_t  dp_stat,
  output ctrl_cmd_t ctrl_cmd
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next      = state;
    s_tready        = 1'b0;
    ctrl_cmd.load   = 1'b0;
    ctrl_cmd.commit = 1'b0;
    unique case (state)
      ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          ctrl_cmd.load = 1'b1;
          state_next    = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (dp_stat.out_free) begin
          ctrl_cmd.commit = 1'b1;
          state_next      = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule

// File: rtl/csem_dp.sv
module csem_dp import csem_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic [COUNT_W-1:0]  cfg_wdata,
  input  logic [S_DATA_W-1:0] s_tdata,
  output logic                m_tvalid,
  input  logic                m_tready,
  output logic [M_DATA_W-1:0] m_tdata,
  input  ctrl_cmd_t           ctrl_cmd,
  output dp_stat_t            dp_stat
);

  localparam logic [WQ_IDX_W-1:0] LAST_IDX = WQ_IDX_W'(MAX_WAITERS - 1);

  logic [COUNT_W-1:0]  cnt, cnt_next;
  logic [WQ_IDX_W-1:0] head, head_next;
  logic [WQ_IDX_W-1:0] tail, tail_next;
  logic [OCC_W-1:0]    occ, occ_next;
  cmd_t                cmd_q;
  logic [ID_W-1:0]     id_q;
  logic                out_valid;
  status_t             out_status, status_next;
  logic                out_woken_valid, woken_valid_next;
  logic [ID_W-1:0]     out_woken_id, woken_id_next;
  logic [COUNT_W-1:0]  out_count;
  logic                push;
  logic [ID_W-1:0]     head_data;

  assign dp_stat.out_free = !out_valid || m_tready;

  csem_ram #(
    .WIDTH(ID_W),
    .DEPTH(MAX_WAITERS)
  ) u_wq (
    .clk  (clk),
    .we   (push),
    .waddr(tail),
    .wdata(id_q),
    .raddr(head),
    .rdata(head_data)
  );

  always_comb begin
    cnt_next         = cnt;
    head_next        = head;
    tail_next        = tail;
    occ_next         = occ;
    status_next      = STAT_OK;
    woken_valid_next = 1'b0;
    woken_id_next    = '0;
    push             = 1'b0;
    case (cmd_q)
      CMD_WAIT: begin
        if (cnt != '0) begin
          cnt_next = cnt - 1'b1;
        end else if (occ < OCC_W'(MAX_WAITERS)) begin
          push        = ctrl_cmd.commit;
          tail_next   = (tail == LAST_IDX) ? '0 : tail + 1'b1;
          occ_next    = occ + 1'b1;
          status_next = STAT_QUEUED;
        end else begin
          status_next = STAT_FULL;
        end
      end
      CMD_POST: begin
        if (occ != '0) begin
          woken_valid_next = 1'b1;
          woken_id_next    = head_data;
          head_next        = (head == LAST_IDX) ? '0 : head + 1'b1;
          occ_next         = occ - 1'b1;
        end else if (cnt < COUNT_W'(COUNT_MAX)) begin
          cnt_next = cnt + 1'b1;
        end else begin
          status_next = STAT_SAT;
        end
      end
      CMD_TRY_WAIT: begin
        if (cnt != '0) begin
          cnt_next = cnt - 1'b1;
        end else begin
          status_next = STAT_BUSY;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt       <= '0;
      head      <= '0;
      tail      <= '0;
      occ       <= '0;
      out_valid <= 1'b0;
    end else if (cfg_we) begin
      cnt  <= (cfg_wdata > COUNT_W'(COUNT_MAX)) ? COUNT_W'(COUNT_MAX) : cfg_wdata;
      head <= '0;
      tail <= '0;
      occ  <= '0;
    end else begin
      if (ctrl_cmd.commit) begin
        cnt       <= cnt_next;
        head      <= head_next;
        tail      <= tail_next;
        occ       <= occ_next;
        out_valid <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl_cmd.load) begin
      cmd_q <= cmd_t'(s_tdata[CMD_W-1:0]);
      id_q  <= s_tdata[CMD_W +: ID_W];
    end
    if (ctrl_cmd.commit) begin
      out_status      <= status_next;
      out_woken_valid <= woken_valid_next;
      out_woken_id    <= woken_id_next;
      out_count       <= cnt_next;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = M_DATA_W'({out_count, out_woken_id, out_woken_valid, out_status});

endmodule

// File: rtl/counting_semaphore_with_wait_queue_top.sv
// Counting semaphore with a bounded FIFO of waiting requesters. Each input transfer carries a
// command (wait, post, try-wait, read count) and a requester id, and yields exactly one output
// transfer with a status, an optional woken waiter id and the count after the operation. An
// item passes a capture state, which captures it and reads the head of the waiter queue from
// its registered RAM, and an execute state, which updates count and queue pointers and loads
// the output register once that register is free. A new item is taken while the previous
// result waits in the output register. Writing the configuration register reloads the count
// and empties the waiter queue; write it only when no item is in flight.
module counting_semaphore_with_wait_queue_top import csem_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic [COUNT_W-1:0]  cfg_wdata,
  input  logic                s_tvalid,
  output logic                s_tready,
  input  logic [S_DATA_W-1:0] s_tdata,  // cmd, requester_id
  output logic                m_tvalid,
  input  logic                m_tready,
  output logic [M_DATA_W-1:0] m_tdata   // status, woken_valid, woken_id, count_value
);

  ctrl_cmd_t ctrl_cmd;
  dp_stat_t  dp_stat;

  csem_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .dp_stat (dp_stat),
    .ctrl_cmd(ctrl_cmd)
  );

  csem_dp u_dp (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .ctrl_cmd (ctrl_cmd),
    .dp_stat  (dp_stat)
  );

endmodule
